@@ sv/srml_pkg.sv @@
package srml_pkg;

	localparam int HDR_DISC_BYTES   = 8;
	localparam int HDR_STORED_BYTES = 4;

	localparam logic MODE_BYTE   = 1'b0;
	localparam logic MODE_LOOKUP = 1'b1;

	localparam logic KIND_LOAD   = 1'b0;
	localparam logic KIND_LOOKUP = 1'b1;

	localparam logic FMT_DISC   = 1'b0;
	localparam logic FMT_STORED = 1'b1;

	localparam logic [1:0] LOAD_OK       = 2'd0;
	localparam logic [1:0] LOAD_SHORT    = 2'd1;
	localparam logic [1:0] LOAD_TOO_MANY = 2'd2;
	localparam logic [1:0] LOAD_ORDER    = 2'd3;

	typedef struct packed {
		logic        mode;
		logic [7:0]  map_byte;
		logic        map_last;
		logic [63:0] lookup_sector;
	} item_t;

	typedef struct packed {
		logic       result_kind;
		logic [1:0] load_status;
		logic       encrypted;
	} result_t;

endpackage

@@ sv/srml_table.sv @@
module srml_table
	import srml_pkg::*;
#(
	parameter int DEPTH = 32,
	parameter int AW    = 5
) (
	input  logic          clk,
	input  logic          we,
	input  logic          we_final,
	input  logic [AW-1:0] waddr,
	input  logic [31:0]   wdata,
	input  logic [AW-1:0] raddr,
	output logic [31:0]   rd_first,
	output logic [31:0]   rd_final
);

	logic [31:0] first_mem [DEPTH];
	logic [31:0] final_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we && !we_final) begin
			first_mem[waddr] <= wdata;
		end
		if (we && we_final) begin
			final_mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rd_first <= first_mem[raddr];
		rd_final <= final_mem[raddr];
	end

endmodule

@@ sv/sector_region_map_lookup_top.sv @@
// Plaintext sector range table: loader and lookup.
// item channel (item_valid / item_stall / item) carries one word per item: either
// one byte of a map image (mode 0) or a sector number to look up (mode 1).
// result channel (result_valid / result_stall / result) returns one word for the
// last byte of a map (load status) and one word for every lookup (encrypted flag).
// cfg_we / cfg_wdata set the map format; write it only while the block is idle.
// a format 0 byte that completes a range end is followed by a start/end order check
// through the table read port; the last byte of a map passes through a finish state
// that registers its status word before it is presented.
// a lookup compares the entries in order and stops at the first hit or the last active range:
// the range table has a single registered read port and one comparator pair that
// walks the entries one per cycle.
// the block takes one item at a time and is stalled while it works on it.
// a stalled result word is held in the output register, and no item is taken
// while a held word waits.
// reset clears the active range count, clears the load state and sets format 0.
module sector_region_map_lookup_top
	import srml_pkg::*;
#(
	parameter int MAX_RANGES = 32
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_stall,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result,
	input  logic    cfg_we,
	input  logic    cfg_wdata
);

	localparam int BYTE_CAP = HDR_DISC_BYTES + 8 * MAX_RANGES + 4;
	localparam int BW       = $clog2(BYTE_CAP + 1);
	localparam int CW       = $clog2(MAX_RANGES + 1);
	localparam int AW       = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_CHECK  = 2'd1;
	localparam logic [1:0] ST_FINISH = 2'd2;
	localparam logic [1:0] ST_LOOK   = 2'd3;

	logic [1:0]    state_q;
	logic          fmt_q;
	logic [BW-1:0] bytes_q;
	logic [31:0]   declared_q;
	logic [31:0]   gather_q;
	logic          fault_q;
	logic          last_q;
	logic [CW-1:0] active_q;
	logic [CW-1:0] chk_q;
	logic [63:0]   sector_q;
	logic          result_valid_q;
	result_t       result_q;

	logic          accept;
	logic [BW-1:0] hdr;
	logic          capped;
	logic [31:0]   gather_nx;
	logic [BW-1:0] pos_rel;
	logic [BW-4:0] slot;
	logic          word_end;
	logic          in_table;
	logic          tbl_we;
	logic [AW-1:0] tbl_raddr;
	logic [31:0]   rd_first;
	logic [31:0]   rd_final;
	logic [CW-1:0] chk_nx;
	logic          hit;
	logic          live;
	logic          look_done;
	logic [BW:0]   need;
	logic [1:0]    status;

	assign accept     = item_valid && !item_stall;
	assign item_stall = (state_q != ST_IDLE) || (result_valid_q && result_stall);

	assign hdr       = (fmt_q == FMT_STORED) ? BW'(HDR_STORED_BYTES) : BW'(HDR_DISC_BYTES);
	assign capped    = bytes_q >= BW'(BYTE_CAP);
	assign gather_nx = (fmt_q == FMT_STORED) ? {item.map_byte, gather_q[31:8]}
	                                         : {gather_q[23:0], item.map_byte};
	assign pos_rel   = bytes_q - hdr;
	assign slot      = pos_rel[BW-1:3];
	assign word_end  = (bytes_q[1:0] == 2'b11) && !capped;
	assign in_table  = word_end && (bytes_q != BW'(3)) && (bytes_q >= hdr)
	                   && (32'(slot) < 32'(MAX_RANGES)) && (32'(slot) < declared_q);
	assign tbl_we    = accept && (item.mode == MODE_BYTE) && in_table;

	assign chk_nx = chk_q + CW'(1);

	always_comb begin
		if (state_q == ST_IDLE) begin
			tbl_raddr = (item.mode == MODE_LOOKUP) ? AW'(0) : AW'(slot);
		end else begin
			tbl_raddr = AW'(chk_nx);
		end
	end

	srml_table #(
		.DEPTH (MAX_RANGES),
		.AW    (AW)
	) u_table (
		.clk      (clk),
		.we       (tbl_we),
		.we_final (pos_rel[2]),
		.waddr    (AW'(slot)),
		.wdata    (gather_nx),
		.raddr    (tbl_raddr),
		.rd_first (rd_first),
		.rd_final (rd_final)
	);

	// one comparator pair against the entry read last cycle
	assign hit       = (sector_q >= {32'b0, rd_first}) && (sector_q <= {32'b0, rd_final});
	assign live      = chk_q < active_q;
	assign look_done = (live && hit) || ({1'b0, chk_nx} >= {1'b0, active_q})
	                   || (chk_q == active_q);

	assign need = (BW+1)'(hdr) + (BW+1)'({declared_q[CW-1:0], 3'b000});

	always_comb begin
		priority if (bytes_q < hdr) begin
			status = LOAD_SHORT;
		end else if (declared_q > 32'(MAX_RANGES)) begin
			status = LOAD_TOO_MANY;
		end else if (declared_q == 32'd0) begin
			status = LOAD_OK;
		end else if ((BW+1)'(bytes_q) < need) begin
			status = LOAD_SHORT;
		end else if (fault_q) begin
			status = LOAD_ORDER;
		end else begin
			status = LOAD_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			fmt_q          <= FMT_DISC;
			bytes_q        <= '0;
			declared_q     <= '0;
			gather_q       <= '0;
			fault_q        <= 1'b0;
			last_q         <= 1'b0;
			active_q       <= '0;
			chk_q          <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				fmt_q <= cfg_wdata;
			end
			if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept && item.mode == MODE_BYTE) begin
						if (bytes_q == '0) begin
							active_q <= '0;
						end
						if (!capped) begin
							bytes_q  <= bytes_q + BW'(1);
							gather_q <= gather_nx;
							if (word_end && bytes_q == BW'(3)) begin
								declared_q <= gather_nx;
							end
						end
						last_q <= item.map_last;
						if (in_table && pos_rel[2] && fmt_q == FMT_DISC) begin
							state_q <= ST_CHECK;
						end else if (item.map_last) begin
							state_q <= ST_FINISH;
						end
					end else if (accept) begin
						chk_q   <= '0;
						state_q <= ST_LOOK;
					end
				end
				ST_CHECK: begin
					if (rd_first > gather_q) begin
						fault_q <= 1'b1;
					end
					state_q <= last_q ? ST_FINISH : ST_IDLE;
				end
				ST_FINISH: begin
					result_valid_q <= 1'b1;
					active_q       <= (status == LOAD_OK && bytes_q >= hdr)
					                  ? declared_q[CW-1:0] : '0;
					bytes_q        <= '0;
					declared_q     <= '0;
					gather_q       <= '0;
					fault_q        <= 1'b0;
					state_q        <= ST_IDLE;
				end
				ST_LOOK: begin
					if (look_done) begin
						result_valid_q <= 1'b1;
						state_q        <= ST_IDLE;
					end else begin
						chk_q <= chk_nx;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept && item.mode == MODE_LOOKUP) begin
			sector_q <= item.lookup_sector;
		end
		if (state_q == ST_FINISH) begin
			result_q <= '{result_kind: KIND_LOAD, load_status: status, encrypted: 1'b0};
		end else if (state_q == ST_LOOK && look_done) begin
			result_q <= '{result_kind: KIND_LOOKUP, load_status: LOAD_OK,
			              encrypted: !(live && hit)};
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule
